FILE: rtl/m4vt_pkg.sv
`default_nettype none

package m4vt_pkg;

	// sizes of the datapath
	localparam int NUM_LANES = 4;
	localparam int NUM_COLS  = 4;
	localparam int NUM_REGS  = 8;
	localparam int WORD_W    = 32;
	localparam int REG_W     = 64;
	localparam int IDX_W     = 4;
	localparam int SLOT_W    = 3;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	// configuration register indexes
	typedef enum logic [SLOT_W-1:0] {
		REG_COEF_A_B = 3'd0,
		REG_COEF_C_D = 3'd1,
		REG_COEF_E_F = 3'd2,
		REG_COEF_G_H = 3'd3,
		REG_COEF_I_J = 3'd4,
		REG_COEF_K_L = 3'd5,
		REG_COEF_M_N = 3'd6,
		REG_COEF_O_P = 3'd7
	} reg_idx_t;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t [NUM_COLS-1:0] vec_t;
	typedef vec_t [NUM_LANES-1:0] mat_t;
	typedef logic signed [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

FILE: rtl/m4vt_coef_bank.sv
`default_nettype none

module m4vt_coef_bank #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [m4vt_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [m4vt_pkg::REG_W-1:0]    cfg_data,
	output m4vt_pkg::mat_t                     coef
);

	localparam logic [m4vt_pkg::REG_W-1:0] ONE_LO = m4vt_pkg::REG_W'(1) << FRAC_BITS;
	localparam logic [m4vt_pkg::REG_W-1:0] ONE_HI = ONE_LO << m4vt_pkg::WORD_W;

	logic [m4vt_pkg::REG_W-1:0] regs_q [m4vt_pkg::NUM_REGS];

	// register file, identity matrix after reset, writes past the last index dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[m4vt_pkg::REG_COEF_A_B] <= ONE_HI;
			regs_q[m4vt_pkg::REG_COEF_C_D] <= '0;
			regs_q[m4vt_pkg::REG_COEF_E_F] <= ONE_LO;
			regs_q[m4vt_pkg::REG_COEF_G_H] <= '0;
			regs_q[m4vt_pkg::REG_COEF_I_J] <= '0;
			regs_q[m4vt_pkg::REG_COEF_K_L] <= ONE_HI;
			regs_q[m4vt_pkg::REG_COEF_M_N] <= '0;
			regs_q[m4vt_pkg::REG_COEF_O_P] <= ONE_LO;
		end else if (cfg_we && (cfg_index < m4vt_pkg::IDX_W'(m4vt_pkg::NUM_REGS))) begin
			regs_q[cfg_index[m4vt_pkg::SLOT_W-1:0]] <= cfg_data;
		end
	end

	// unpack into rows and columns, even column in the upper half
	always_comb begin
		for (int r = 0; r < m4vt_pkg::NUM_LANES; r++) begin
			for (int c = 0; c < m4vt_pkg::NUM_COLS; c++) begin
				if ((c % 2) == 0) begin
					coef[r][c] = regs_q[m4vt_pkg::SLOT_W'(2 * r + c / 2)]
						[m4vt_pkg::REG_W-1:m4vt_pkg::WORD_W];
				end else begin
					coef[r][c] = regs_q[m4vt_pkg::SLOT_W'(2 * r + c / 2)]
						[m4vt_pkg::WORD_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/m4vt_lane.sv
`default_nettype none

module m4vt_lane (
	input  wire logic           clk,
	input  wire m4vt_pkg::vec_t vec,
	input  wire m4vt_pkg::vec_t row,
	output m4vt_pkg::sum_t      sum_s3
);

	logic signed [m4vt_pkg::PROD_W-1:0] prod_s1 [m4vt_pkg::NUM_COLS];
	logic signed [m4vt_pkg::PAIR_W-1:0] pair_s2 [2];

	// one multiplier per column
	always_ff @(posedge clk) begin
		for (int c = 0; c < m4vt_pkg::NUM_COLS; c++) begin
			prod_s1[c] <= m4vt_pkg::PROD_W'($signed(row[c])) *
				m4vt_pkg::PROD_W'($signed(vec[c]));
		end
	end

	// pairwise sums
	always_ff @(posedge clk) begin
		pair_s2[0] <= m4vt_pkg::PAIR_W'(prod_s1[0]) + m4vt_pkg::PAIR_W'(prod_s1[1]);
		pair_s2[1] <= m4vt_pkg::PAIR_W'(prod_s1[2]) + m4vt_pkg::PAIR_W'(prod_s1[3]);
	end

	// exact row total
	always_ff @(posedge clk) begin
		sum_s3 <= m4vt_pkg::SUM_W'(pair_s2[0]) + m4vt_pkg::SUM_W'(pair_s2[1]);
	end

endmodule

`default_nettype wire

FILE: rtl/matrix4_vector_transform.sv
`default_nettype none

// 4x4 matrix times 4-vector transform, signed fixed point with FRAC_BITS
// fraction bits.
// input: a word (in_x, in_y, in_z, in_w) is taken at a rising edge with start
// high and busy low. busy is always low, so one word per cycle is accepted.
// output: the result word (out_x..out_w) is shown for one cycle with done high;
// done rises after the product, pair-sum, row-total and result registers;
// one result per cycle sustained. the receiver cannot stall; none is needed.
// each row runs in its own lane: four multipliers, a two-level adder tree,
// then a shared stage shifts each total right by FRAC_BITS (toward minus
// infinity) and saturates it to 32 bits.
// config: cfg_we writes cfg_data into register cfg_index at once; indexes
// past seven are ignored. write only while no word is in flight.
// reset: asynchronous, clears the pipeline valid bits and loads the identity
// matrix; no clearing pass is needed.
module matrix4_vector_transform #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [31:0]            in_x,
	input  wire logic signed [31:0]            in_y,
	input  wire logic signed [31:0]            in_z,
	input  wire logic signed [31:0]            in_w,
	output logic                               done,
	output logic signed [31:0]                 out_x,
	output logic signed [31:0]                 out_y,
	output logic signed [31:0]                 out_z,
	output logic signed [31:0]                 out_w,
	input  wire logic                          cfg_we,
	input  wire logic [m4vt_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [m4vt_pkg::REG_W-1:0]    cfg_data
);

	m4vt_pkg::mat_t  coef;
	m4vt_pkg::vec_t  vec;
	m4vt_pkg::sum_t  lane_sum [m4vt_pkg::NUM_LANES];
	m4vt_pkg::word_t res_q [m4vt_pkg::NUM_LANES];
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	logic            done_q;

	// shift toward minus infinity, clamp to signed 32 bits
	function automatic m4vt_pkg::word_t sat_shift(input m4vt_pkg::sum_t s);
		m4vt_pkg::sum_t sh;
		logic           all_ones;
		logic           all_zeros;
		sh        = s >>> FRAC_BITS;
		all_ones  = &sh[m4vt_pkg::SUM_W-1:m4vt_pkg::WORD_W-1];
		all_zeros = ~|sh[m4vt_pkg::SUM_W-1:m4vt_pkg::WORD_W-1];
		if (sh[m4vt_pkg::SUM_W-1] && !all_ones) begin
			sat_shift = {1'b1, {(m4vt_pkg::WORD_W-1){1'b0}}};
		end else if (!sh[m4vt_pkg::SUM_W-1] && !all_zeros) begin
			sat_shift = {1'b0, {(m4vt_pkg::WORD_W-1){1'b1}}};
		end else begin
			sat_shift = sh[m4vt_pkg::WORD_W-1:0];
		end
	endfunction

	// never stalls
	assign busy = 1'b0;

	assign vec[0] = in_x;
	assign vec[1] = in_y;
	assign vec[2] = in_z;
	assign vec[3] = in_w;

	m4vt_coef_bank #(
		.FRAC_BITS (FRAC_BITS)
	) u_coef_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// one lane per matrix row
	for (genvar r = 0; r < m4vt_pkg::NUM_LANES; r++) begin : g_lane
		m4vt_lane u_lane (
			.clk    (clk),
			.vec    (vec),
			.row    (coef[r]),
			.sum_s3 (lane_sum[r])
		);
	end

	// valid bits follow the word down the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// merge stage: scale and saturate all four lanes into the result word
	always_ff @(posedge clk) begin
		for (int r = 0; r < m4vt_pkg::NUM_LANES; r++) begin
			res_q[r] <= sat_shift(lane_sum[r]);
		end
	end

	assign done  = done_q;
	assign out_x = res_q[0];
	assign out_y = res_q[1];
	assign out_z = res_q[2];
	assign out_w = res_q[3];

endmodule

`default_nettype wire

FILE: tb/matrix4_vector_transform_tb.sv
`timescale 1ns / 100ps

module matrix4_vector_transform_tb;

	localparam int FRAC_BITS = 16;
	localparam m4vt_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam m4vt_pkg::word_t WORD_MIN = 32'sh8000_0000;
	localparam m4vt_pkg::word_t ONE_WORD = m4vt_pkg::word_t'(1 << FRAC_BITS);
	localparam m4vt_pkg::word_t HALF_WORD = m4vt_pkg::word_t'(1 << (FRAC_BITS - 1));
	localparam int WORDS_PER_MATRIX = 96;

	typedef logic [m4vt_pkg::REG_W-1:0] coef_set_t [m4vt_pkg::NUM_REGS];

	// expected transform results, predicted from a private copy of the matrix
	class xform_scoreboard;
		logic [m4vt_pkg::REG_W-1:0] coef [m4vt_pkg::NUM_REGS];
		m4vt_pkg::vec_t expected_q [$];
		int err_count;

		function new();
			foreach (coef[i])
				coef[i] = '0;
			// identity after reset
			coef[m4vt_pkg::REG_COEF_A_B] = {ONE_WORD, 32'h0};
			coef[m4vt_pkg::REG_COEF_E_F] = {32'h0, ONE_WORD};
			coef[m4vt_pkg::REG_COEF_K_L] = {ONE_WORD, 32'h0};
			coef[m4vt_pkg::REG_COEF_O_P] = {32'h0, ONE_WORD};
			err_count = 0;
		endfunction

		// indexes past the last register are dropped
		function void write_reg(logic [m4vt_pkg::IDX_W-1:0] idx,
			logic [m4vt_pkg::REG_W-1:0] data);
			if (idx < m4vt_pkg::NUM_REGS)
				coef[idx[m4vt_pkg::SLOT_W-1:0]] = data;
		endfunction

		// exact dot product, floor shift, saturate to a word
		function m4vt_pkg::word_t row_dot(int row, m4vt_pkg::vec_t v);
			m4vt_pkg::sum_t acc;
			m4vt_pkg::word_t cf;
			logic [m4vt_pkg::REG_W-1:0] pair;
			acc = '0;
			for (int c = 0; c < m4vt_pkg::NUM_COLS; c++) begin
				pair = coef[row * 2 + c / 2];
				cf = (c % 2 == 0) ? pair[m4vt_pkg::REG_W-1:m4vt_pkg::WORD_W] :
					pair[m4vt_pkg::WORD_W-1:0];
				acc = acc + m4vt_pkg::sum_t'($signed(cf)) *
					m4vt_pkg::sum_t'($signed(v[c]));
			end
			acc = acc >>> FRAC_BITS;
			if (acc > m4vt_pkg::sum_t'(WORD_MAX))
				return WORD_MAX;
			if (acc < m4vt_pkg::sum_t'(WORD_MIN))
				return WORD_MIN;
			return m4vt_pkg::word_t'(acc);
		endfunction

		function void note_input(m4vt_pkg::vec_t v);
			m4vt_pkg::vec_t res;
			for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
				res[r] = row_dot(r, v);
			expected_q.push_back(res);
		endfunction

		function void check_result(m4vt_pkg::vec_t got);
			m4vt_pkg::vec_t want;
			string lane_name [m4vt_pkg::NUM_LANES] = '{"out_x", "out_y", "out_z", "out_w"};
			if (expected_q.size() == 0) begin
				$display("%0t: result word with none expected: %h", $time, got);
				err_count++;
				return;
			end
			want = expected_q.pop_front();
			for (int i = 0; i < m4vt_pkg::NUM_LANES; i++) begin
				if (want[i] !== got[i]) begin
					$display("%0t: %s mismatch: expected %0d, actual %0d",
						$time, lane_name[i], $signed(want[i]), $signed(got[i]));
					err_count++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	m4vt_pkg::word_t in_x, in_y, in_z, in_w;
	logic done;
	m4vt_pkg::word_t out_x, out_y, out_z, out_w;
	logic cfg_we;
	logic [m4vt_pkg::IDX_W-1:0] cfg_index;
	logic [m4vt_pkg::REG_W-1:0] cfg_data;

	xform_scoreboard sb;
	int sender_idle_pct;

	matrix4_vector_transform #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.in_w(in_w),
		.done(done),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.out_w(out_w),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// watch both sides of the block at every edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result({out_w, out_z, out_y, out_x});
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_input({in_w, in_z, in_y, in_x});
		end
	end

	// mix of extremes, small magnitudes and full-range values
	function automatic m4vt_pkg::word_t rand_word();
		case ($urandom_range(7))
			0, 1: begin
				case ($urandom_range(6))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					3: return m4vt_pkg::word_t'(1);
					4: return m4vt_pkg::word_t'(-1);
					5: return ONE_WORD;
					default: return -ONE_WORD;
				endcase
			end
			2, 3, 4: return m4vt_pkg::word_t'($urandom_range(1 << 19)) -
				m4vt_pkg::word_t'(1 << 18);
			default: return m4vt_pkg::word_t'($urandom);
		endcase
	endfunction

	// one word in, with random gaps carrying noise on the data lines
	task automatic send_vector(input m4vt_pkg::word_t x, input m4vt_pkg::word_t y,
		input m4vt_pkg::word_t z, input m4vt_pkg::word_t w);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			in_x <= $urandom;
			in_y <= $urandom;
			in_z <= $urandom;
			in_w <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		in_w <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending and wait for every expected result
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_coef(input logic [m4vt_pkg::IDX_W-1:0] idx,
		input logic [m4vt_pkg::REG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// full matrix load with one write to an unmapped index mixed in
	task automatic load_matrix(input coef_set_t m);
		int stray;
		stray = $urandom_range(m4vt_pkg::NUM_REGS - 1);
		for (int i = 0; i < m4vt_pkg::NUM_REGS; i++) begin
			if (i == stray)
				write_coef(m4vt_pkg::IDX_W'($urandom_range((1 << m4vt_pkg::IDX_W) - 1,
					m4vt_pkg::NUM_REGS)), {$urandom, $urandom});
			write_coef(m4vt_pkg::IDX_W'(i), m[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		coef_set_t m;
		int phase_idle [3];
		phase_idle = '{7, 72, 0};
		sb = new();
		arst_n = 1'b0;
		start <= 1'b0;
		in_x <= '0;
		in_y <= '0;
		in_z <= '0;
		in_w <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sender_idle_pct = 7;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix out of reset
		send_vector('0, '0, '0, '0);
		send_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
		send_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		send_vector(m4vt_pkg::word_t'(1), m4vt_pkg::word_t'(-1), ONE_WORD, -ONE_WORD);
		drain();

		// largest positive coefficients, overflow both ways
		foreach (m[i])
			m[i] = {WORD_MAX, WORD_MAX};
		load_matrix(m);
		send_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
		send_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		send_vector(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
		send_vector(ONE_WORD, '0, '0, '0);
		drain();

		// most negative coefficients
		foreach (m[i])
			m[i] = {WORD_MIN, WORD_MIN};
		load_matrix(m);
		send_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		send_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
		send_vector(m4vt_pkg::word_t'(1), m4vt_pkg::word_t'(1), m4vt_pkg::word_t'(1),
			m4vt_pkg::word_t'(1));
		drain();

		// negative sums must round toward minus infinity
		m[m4vt_pkg::REG_COEF_A_B] = {HALF_WORD, 32'h0};
		m[m4vt_pkg::REG_COEF_C_D] = '0;
		m[m4vt_pkg::REG_COEF_E_F] = '1;
		m[m4vt_pkg::REG_COEF_G_H] = '1;
		m[m4vt_pkg::REG_COEF_I_J] = {ONE_WORD, ONE_WORD};
		m[m4vt_pkg::REG_COEF_K_L] = {ONE_WORD, ONE_WORD};
		m[m4vt_pkg::REG_COEF_M_N] = '0;
		m[m4vt_pkg::REG_COEF_O_P] = '0;
		load_matrix(m);
		send_vector(m4vt_pkg::word_t'(-1), m4vt_pkg::word_t'(-1), m4vt_pkg::word_t'(-1),
			m4vt_pkg::word_t'(-1));
		send_vector(m4vt_pkg::word_t'(1), m4vt_pkg::word_t'(1), m4vt_pkg::word_t'(1),
			m4vt_pkg::word_t'(1));
		send_vector(m4vt_pkg::word_t'(-3), m4vt_pkg::word_t'(5), WORD_MIN, WORD_MAX);
		send_vector(m4vt_pkg::word_t'(-(1 << 16) - 1), m4vt_pkg::word_t'(7),
			m4vt_pkg::word_t'(-9), ONE_WORD);
		drain();

		// random matrices and vectors under each sender pace
		foreach (phase_idle[p]) begin
			sender_idle_pct = phase_idle[p];
			for (int blk = 0; blk < 4; blk++) begin
				foreach (m[i])
					m[i] = {rand_word(), rand_word()};
				load_matrix(m);
				repeat (WORDS_PER_MATRIX)
					send_vector(rand_word(), rand_word(), rand_word(), rand_word());
				drain();
			end
		end

		// let the pipeline empty; catch anything stray
		repeat (8) @(posedge clk);
		if (sb.err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
